// ===== rtl/core/work_stealing_job_scheduler_unit_defines.svh =====
// Assertion macros for the checker file.
`ifndef WORK_STEALING_JOB_SCHEDULER_UNIT_DEFINES_SVH
`define WORK_STEALING_JOB_SCHEDULER_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define WSJS_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define WSJS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/wsjs_pkg.sv =====
// ----------------------------------------------------------------------------
// wsjs_pkg
// Shared types and constants of the work-stealing job scheduler.
// ----------------------------------------------------------------------------
package wsjs_pkg;

  localparam int MaxWorkers     = 8;
  localparam int PriorityLevels = 3;
  localparam int QueueDepth     = 16;
  localparam int JobIdBits      = 8;
  localparam int NumQueues      = MaxWorkers * PriorityLevels;
  localparam int WidBits        = 3;
  localparam int PrioBits       = 2;
  localparam int QBits          = $clog2(NumQueues);
  localparam int PtrBits        = $clog2(QueueDepth);
  localparam int FillBits       = PtrBits + 1;
  localparam int SlotBits       = QBits + PtrBits;
  localparam int SlotDepth      = NumQueues * QueueDepth;
  localparam int CntBits        = WidBits + 1;

  // Request codes.
  localparam logic [1:0] ReqPush  = 2'd0;
  localparam logic [1:0] ReqGet   = 2'd1;
  localparam logic [1:0] ReqSleep = 2'd2;

  // Status codes.
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StRange  = 2'd2;
  localparam logic [1:0] StMisuse = 2'd3;

  // Job source codes.
  localparam logic [1:0] SrcNone  = 2'd0;
  localparam logic [1:0] SrcOwn   = 2'd1;
  localparam logic [1:0] SrcSteal = 2'd2;

  // Result fields, with the slot read pending.
  typedef struct packed {
    logic                 job_found;
    logic [1:0]           job_source;
    logic [WidBits-1:0]   chosen_worker;
    logic                 wake_worker;
    logic [1:0]           status;
  } result_t;

endpackage

// ===== rtl/core/wsjs_ram.sv =====
// ----------------------------------------------------------------------------
// wsjs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module wsjs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/wsjs_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsjs_ctrl
// Queue pointers, sleeper stack and request decision for one request.
// ----------------------------------------------------------------------------
module wsjs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [3:0]                    active_workers,
  input  logic [1:0]                    req_type,
  input  logic [wsjs_pkg::WidBits-1:0]  worker_id,
  input  logic                          from_worker,
  input  logic [1:0]                    job_priority,
  input  logic [wsjs_pkg::WidBits-1:0]  random_pick,
  output logic                          slot_we,
  output logic [wsjs_pkg::SlotBits-1:0] slot_addr,
  output wsjs_pkg::result_t             res
);

  logic [wsjs_pkg::PtrBits-1:0]  queue_head [wsjs_pkg::NumQueues];
  logic [wsjs_pkg::FillBits-1:0] queue_fill [wsjs_pkg::NumQueues];
  logic [wsjs_pkg::WidBits-1:0]  sleeper_stack [wsjs_pkg::MaxWorkers];
  logic [wsjs_pkg::CntBits-1:0]  sleeper_count;

  logic [wsjs_pkg::CntBits-1:0]  n;
  logic [1:0]                    prio;
  logic [wsjs_pkg::WidBits-1:0]  top_sleeper;
  logic [wsjs_pkg::WidBits-1:0]  target;
  logic [wsjs_pkg::WidBits-1:0]  victim;
  logic [wsjs_pkg::QBits-1:0]    q;
  logic                          do_fill;
  logic                          do_head;
  logic                          do_pop;
  logic                          do_sleep;
  logic                          dup;
  logic                          own_hit;
  logic                          steal_hit;
  logic [1:0]                    own_p;
  logic [1:0]                    steal_p;
  logic [wsjs_pkg::QBits-1:0]    own_q;
  logic [wsjs_pkg::QBits-1:0]    steal_q;
  logic [wsjs_pkg::FillBits-1:0] fq;

  // Clamp the worker count and priority; pick the top sleeper and the victim.
  always_comb begin
    n = active_workers;
    if (n == '0) begin
      n = wsjs_pkg::CntBits'(1);
    end else if (n > wsjs_pkg::CntBits'(wsjs_pkg::MaxWorkers)) begin
      n = wsjs_pkg::CntBits'(wsjs_pkg::MaxWorkers);
    end
    prio = (job_priority >= 2'(wsjs_pkg::PriorityLevels)) ?
           2'(wsjs_pkg::PriorityLevels - 1) : job_priority;
    top_sleeper = sleeper_stack[3'(sleeper_count - 1'b1)];
    victim = (random_pick >= worker_id) ? random_pick + 1'b1 : random_pick;
  end

  // First nonempty level for the caller and the victim, and the duplicate sleeper check.
  always_comb begin
    own_hit   = 1'b0;
    steal_hit = 1'b0;
    own_p     = '0;
    steal_p   = '0;
    for (int p = wsjs_pkg::PriorityLevels - 1; p >= 0; p--) begin
      if (queue_fill[wsjs_pkg::QBits'(worker_id * wsjs_pkg::PriorityLevels + p)] != '0) begin
        own_hit = 1'b1;
        own_p   = 2'(p);
      end
      if (queue_fill[wsjs_pkg::QBits'(victim * wsjs_pkg::PriorityLevels + p)] != '0) begin
        steal_hit = 1'b1;
        steal_p   = 2'(p);
      end
    end
    own_q   = wsjs_pkg::QBits'(worker_id * wsjs_pkg::PriorityLevels + own_p);
    steal_q = wsjs_pkg::QBits'(victim * wsjs_pkg::PriorityLevels + steal_p);
    dup = 1'b0;
    for (int i = 0; i < wsjs_pkg::MaxWorkers; i++) begin
      if (wsjs_pkg::CntBits'(i) < sleeper_count && sleeper_stack[i] == worker_id) begin
        dup = 1'b1;
      end
    end
  end

  // Request decision.
  always_comb begin
    res       = '0;
    target    = '0;
    q         = '0;
    do_fill   = 1'b0;
    do_head   = 1'b0;
    do_pop    = 1'b0;
    do_sleep  = 1'b0;
    slot_we   = 1'b0;
    fq        = '0;
    slot_addr = '0;
    case (req_type)
      wsjs_pkg::ReqPush: begin
        if (sleeper_count != '0) begin
          target = top_sleeper;
        end else if (from_worker) begin
          target = worker_id;
        end else begin
          target = random_pick;
        end
        if (sleeper_count == '0 && {1'b0, target} >= n) begin
          res.status = wsjs_pkg::StRange;
        end else begin
          q  = wsjs_pkg::QBits'(target * wsjs_pkg::PriorityLevels + prio);
          fq = queue_fill[q];
          res.chosen_worker = target;
          if (fq >= wsjs_pkg::FillBits'(wsjs_pkg::QueueDepth)) begin
            res.status = wsjs_pkg::StFull;
          end else begin
            slot_we   = 1'b1;
            slot_addr = {q, wsjs_pkg::PtrBits'(queue_head[q] + fq)};
            do_fill   = 1'b1;
            if (sleeper_count != '0) begin
              do_pop = 1'b1;
              res.wake_worker = 1'b1;
            end
          end
        end
      end
      wsjs_pkg::ReqGet: begin
        if ({1'b0, worker_id} >= n) begin
          res.status = wsjs_pkg::StRange;
        end else if (own_hit) begin
          q = own_q;
          slot_addr = {q, queue_head[q]};
          do_head = 1'b1;
          res.job_found = 1'b1;
          res.job_source = wsjs_pkg::SrcOwn;
          res.chosen_worker = worker_id;
        end else if (n > wsjs_pkg::CntBits'(1)) begin
          if ({1'b0, random_pick} > n - wsjs_pkg::CntBits'(2)) begin
            res.status = wsjs_pkg::StRange;
          end else if (steal_hit) begin
            q = steal_q;
            slot_addr = {q, wsjs_pkg::PtrBits'(queue_head[q] + queue_fill[q] - 1'b1)};
            res.job_found = 1'b1;
            res.job_source = wsjs_pkg::SrcSteal;
            res.chosen_worker = victim;
          end
        end
      end
      wsjs_pkg::ReqSleep: begin
        if ({1'b0, worker_id} >= n) begin
          res.status = wsjs_pkg::StRange;
        end else begin
          res.chosen_worker = worker_id;
          if (dup || sleeper_count >= wsjs_pkg::CntBits'(wsjs_pkg::MaxWorkers)) begin
            res.status = wsjs_pkg::StMisuse;
          end else begin
            do_sleep = 1'b1;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
    slot_we = slot_we & go;
  end

  // State update on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wsjs_pkg::NumQueues; i++) begin
        queue_head[i] <= '0;
        queue_fill[i] <= '0;
      end
      sleeper_count <= '0;
    end else if (go) begin
      if (do_fill) begin
        queue_fill[q] <= queue_fill[q] + 1'b1;
      end else if (res.job_found) begin
        queue_fill[q] <= queue_fill[q] - 1'b1;
      end
      if (do_head) begin
        queue_head[q] <= queue_head[q] + 1'b1;
      end
      if (do_pop) begin
        sleeper_count <= sleeper_count - 1'b1;
      end else if (do_sleep) begin
        sleeper_count <= sleeper_count + 1'b1;
      end
    end
  end

  // Sleeper stack entries need no reset.
  always_ff @(posedge clk) begin
    if (go && do_sleep) begin
      sleeper_stack[3'(sleeper_count)] <= worker_id;
    end
  end

endmodule

// ===== rtl/core/work_stealing_job_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// work_stealing_job_scheduler_unit
// Work-stealing scheduler with per-worker priority deques and a sleeper stack.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers when start is high and busy is low. Requests are push
//   (job into a worker queue), get (pop own queue front or steal a victim's
//   back) and sleep (caller onto the sleeper stack).
//   The one result of each request is on the result ports after the result
//   register res_q and the output registers, marked by done for exactly one
//   cycle; the receiver cannot stall it.
//   Decisions and pointer updates happen in the accept cycle; the slot memory
//   read is registered beside res_q, and the output registers follow.
//   busy is always low, so a request can transfer every cycle: throughput is
//   one request per cycle.
//   active_workers is written through cfg_we / cfg_data; the user writes it
//   only while idle, which the block itself does not enforce.
//   Synchronous reset empties all queues and the sleeper stack and sets
//   active_workers to eight; slot contents stay undefined until written.
// ----------------------------------------------------------------------------
module work_stealing_job_scheduler_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [2:0] worker_id,
  input  logic       from_worker,
  input  logic [7:0] job_id,
  input  logic [1:0] job_priority,
  input  logic [2:0] random_pick,
  output logic       done,
  output logic       job_found,
  output logic [7:0] out_job,
  output logic [1:0] job_source,
  output logic [2:0] chosen_worker,
  output logic       wake_worker,
  output logic [1:0] status
);

  logic [3:0]                    active_workers;
  logic                          go;
  logic                          slot_we;
  logic [wsjs_pkg::SlotBits-1:0] slot_addr;
  logic [7:0]                    slot_rdata;
  wsjs_pkg::result_t             res;
  wsjs_pkg::result_t             res_q;
  logic                          valid_q;

  assign busy = 1'b0;
  assign go   = start & ~busy;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= 4'd8;
    end else if (cfg_we) begin
      active_workers <= cfg_data;
    end
  end

  wsjs_ctrl u_ctrl (
    .clk, .rst, .go, .active_workers, .req_type, .worker_id, .from_worker,
    .job_priority, .random_pick, .slot_we, .slot_addr, .res
  );

  wsjs_ram #(.Width(wsjs_pkg::JobIdBits), .Depth(wsjs_pkg::SlotDepth)) u_slots (
    .clk, .we(slot_we), .waddr(slot_addr), .wdata(job_id),
    .raddr(slot_addr), .rdata(slot_rdata)
  );

  // Stage one: result held while the slot read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_q <= go;
      done    <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    res_q         <= res;
    job_found     <= res_q.job_found;
    out_job       <= res_q.job_found ? slot_rdata : 8'd0;
    job_source    <= res_q.job_source;
    chosen_worker <= res_q.chosen_worker;
    wake_worker   <= res_q.wake_worker;
    status        <= res_q.status;
  end

endmodule

// ===== rtl/core/wsjs_checker.sv =====
// ----------------------------------------------------------------------------
// wsjs_checker
// Port-level checks of the scheduler's results.
// ----------------------------------------------------------------------------
`include "work_stealing_job_scheduler_unit_defines.svh"

module wsjs_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       job_found,
  input logic [7:0] out_job,
  input logic [1:0] job_source,
  input logic       wake_worker,
  input logic [1:0] status
);

  `WSJS_ASSERT_IMPL(a_found_src, clk, rst, done && job_found, job_source != wsjs_pkg::SrcNone && status == wsjs_pkg::StOk)
  `WSJS_ASSERT_IMPL(a_nofound, clk, rst, done && !job_found, out_job == 8'd0 && job_source == wsjs_pkg::SrcNone)
  `WSJS_ASSERT_IMPL(a_wake_ok, clk, rst, done && wake_worker, status == wsjs_pkg::StOk && !job_found)
  `WSJS_ASSERT_NEXT(a_latency, clk, rst, start && !busy, ##1 done)

endmodule

bind work_stealing_job_scheduler_unit wsjs_checker u_wsjs_checker (
  .clk, .rst, .start, .busy, .done, .job_found, .out_job, .job_source,
  .wake_worker, .status
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the work-stealing job scheduler. A directed table
// covers the corner cases, then random requests run under several worker
// counts. A request is scored against the table's expected result if it has
// one, else against a cycle-free model of the queues and the sleeper stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ReqUnknown = 2'd3;
  localparam int         IdleLimit  = 1000;
  localparam int         PhaseItems = 68;
  localparam int         ExpDepth   = 64;
  localparam int         RowDepth   = 64;

  typedef struct packed {
    logic       job_found;
    logic [7:0] out_job;
    logic [1:0] job_source;
    logic [2:0] chosen_worker;
    logic       wake_worker;
    logic [1:0] status;
  } sched_result_t;

  typedef struct packed {
    logic [1:0]    req;
    logic [2:0]    wid;
    logic          from_w;
    logic [7:0]    job;
    logic [1:0]    prio;
    logic [2:0]    pick;
    logic          has_exp;
    sched_result_t exp;
  } sched_req_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_data;
  logic       start;
  logic       busy;
  logic [1:0] req_type;
  logic [2:0] worker_id;
  logic       from_worker;
  logic [7:0] job_id;
  logic [1:0] job_priority;
  logic [2:0] random_pick;
  logic       done;
  logic       job_found;
  logic [7:0] out_job;
  logic [1:0] job_source;
  logic [2:0] chosen_worker;
  logic       wake_worker;
  logic [1:0] status;

  // Scheduler state as the bench tracks it.
  logic [7:0] slot_mem [wsjs_pkg::NumQueues][wsjs_pkg::QueueDepth];
  int         q_head   [wsjs_pkg::NumQueues];
  int         q_fill   [wsjs_pkg::NumQueues];
  int         sleepers [wsjs_pkg::MaxWorkers];
  int         sleeper_cnt;
  int         workers_cfg;

  // Expected results in order of request transfer.
  sched_result_t exp_fifo [ExpDepth];
  int            exp_wr = 0;
  int            exp_rd = 0;
  sched_req_t    directed_rows [RowDepth];
  int            row_count = 0;
  int            fail_count = 0;
  int            idle_cycles = 0;

  work_stealing_job_scheduler_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .req_type(req_type), .worker_id(worker_id),
    .from_worker(from_worker), .job_id(job_id), .job_priority(job_priority),
    .random_pick(random_pick), .done(done), .job_found(job_found),
    .out_job(out_job), .job_source(job_source), .chosen_worker(chosen_worker),
    .wake_worker(wake_worker), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int active_count();
    int n;
    n = workers_cfg;
    if (n < 1) n = 1;
    if (n > wsjs_pkg::MaxWorkers) n = wsjs_pkg::MaxWorkers;
    return n;
  endfunction

  // Pops one job from worker w, level 0 first: front for the owner, back for a thief.
  function automatic bit pop_job(int w, bit own, output logic [7:0] job);
    int q;
    job = '0;
    for (int p = 0; p < wsjs_pkg::PriorityLevels; p++) begin
      q = w * wsjs_pkg::PriorityLevels + p;
      if (q_fill[q] != 0) begin
        if (own) begin
          job = slot_mem[q][q_head[q]];
          q_head[q] = (q_head[q] + 1) % wsjs_pkg::QueueDepth;
        end else begin
          job = slot_mem[q][(q_head[q] + q_fill[q] - 1) % wsjs_pkg::QueueDepth];
        end
        q_fill[q]--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the tracked state and returns its result.
  function automatic sched_result_t schedule_request(sched_req_t it);
    sched_result_t r;
    int n, prio, target, q, victim;
    bit ok, from_sleeper, dup;
    logic [7:0] job;
    r = '0;
    n = active_count();
    prio = (int'(it.prio) >= wsjs_pkg::PriorityLevels) ?
           wsjs_pkg::PriorityLevels - 1 : int'(it.prio);
    case (it.req)
      wsjs_pkg::ReqPush: begin
        ok = 1'b1;
        from_sleeper = 1'b0;
        target = 0;
        if (sleeper_cnt > 0) begin
          target = sleepers[sleeper_cnt - 1];
          from_sleeper = 1'b1;
        end else if (it.from_w) begin
          if (int'(it.wid) >= n) ok = 1'b0; else target = int'(it.wid);
        end else begin
          if (int'(it.pick) >= n) ok = 1'b0; else target = int'(it.pick);
        end
        if (!ok) begin
          r.status = wsjs_pkg::StRange;
        end else begin
          q = target * wsjs_pkg::PriorityLevels + prio;
          r.chosen_worker = 3'(target);
          if (q_fill[q] >= wsjs_pkg::QueueDepth) begin
            r.status = wsjs_pkg::StFull;
          end else begin
            slot_mem[q][(q_head[q] + q_fill[q]) % wsjs_pkg::QueueDepth] = it.job;
            q_fill[q]++;
            if (from_sleeper) begin
              sleeper_cnt--;
              r.wake_worker = 1'b1;
            end
          end
        end
      end
      wsjs_pkg::ReqGet: begin
        if (int'(it.wid) >= n) begin
          r.status = wsjs_pkg::StRange;
        end else if (pop_job(int'(it.wid), 1'b1, job)) begin
          r.job_found = 1'b1;
          r.out_job = job;
          r.job_source = wsjs_pkg::SrcOwn;
          r.chosen_worker = it.wid;
        end else if (n > 1) begin
          if (int'(it.pick) > n - 2) begin
            r.status = wsjs_pkg::StRange;
          end else begin
            victim = (it.pick >= it.wid) ? int'(it.pick) + 1 : int'(it.pick);
            if (pop_job(victim, 1'b0, job)) begin
              r.job_found = 1'b1;
              r.out_job = job;
              r.job_source = wsjs_pkg::SrcSteal;
              r.chosen_worker = 3'(victim);
            end
          end
        end
      end
      wsjs_pkg::ReqSleep: begin
        if (int'(it.wid) >= n) begin
          r.status = wsjs_pkg::StRange;
        end else begin
          dup = 1'b0;
          for (int i = 0; i < sleeper_cnt; i++)
            if (sleepers[i] == int'(it.wid)) dup = 1'b1;
          r.chosen_worker = it.wid;
          if (dup || sleeper_cnt >= wsjs_pkg::MaxWorkers) begin
            r.status = wsjs_pkg::StMisuse;
          end else begin
            sleepers[sleeper_cnt] = int'(it.wid);
            sleeper_cnt++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [1:0] req, int wid, bit fw, int job, int prio,
                                  int pick, bit has_exp, sched_result_t exp);
    sched_req_t it;
    it = '{req, wid[2:0], fw, job[7:0], prio[1:0], pick[2:0], has_exp, exp};
    directed_rows[row_count] = it;
    row_count++;
  endfunction

  // Random request: mostly in-range workers and picks, with a push bias per phase.
  function automatic sched_req_t random_request(int push_pct);
    sched_req_t it;
    int n, roll;
    n = active_count();
    it = '0;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) it.req = wsjs_pkg::ReqPush;
    else if (roll < 88) it.req = wsjs_pkg::ReqGet;
    else if (roll < 97) it.req = wsjs_pkg::ReqSleep;
    else it.req = ReqUnknown;
    it.wid = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
             3'($urandom_range(0, n - 1));
    it.from_w = 1'($urandom_range(0, 1));
    it.job = 8'($urandom_range(0, 255));
    it.prio = 2'($urandom_range(0, 3));
    it.pick = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) :
              3'($urandom_range(0, n - 1));
    return it;
  endfunction

  // Drives one request, waits for its transfer and records its expected result.
  task automatic send_request(sched_req_t it);
    sched_result_t r;
    int gap;
    req_type <= it.req;
    worker_id <= it.wid;
    from_worker <= it.from_w;
    job_id <= it.job;
    job_priority <= it.prio;
    random_pick <= it.pick;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = schedule_request(it);
    exp_fifo[exp_wr % ExpDepth] = it.has_exp ? it.exp : r;
    exp_wr++;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes the worker count once every result is back.
  task automatic set_workers(int value);
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    workers_cfg = value;
  endtask

  task automatic check_field(string name, int exp, int act);
    if (exp != act) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      fail_count++;
    end
  endtask

  // Scores each result transfer against the oldest expectation.
  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && done) begin
      if (exp_wr == exp_rd) begin
        $error("result transfer with no request outstanding");
        fail_count++;
      end else begin
        e = exp_fifo[exp_rd % ExpDepth];
        exp_rd++;
        check_field("job_found", int'(e.job_found), int'(job_found));
        check_field("out_job", int'(e.out_job), int'(out_job));
        check_field("job_source", int'(e.job_source), int'(job_source));
        check_field("chosen_worker", int'(e.chosen_worker), int'(chosen_worker));
        check_field("wake_worker", int'(e.wake_worker), int'(wake_worker));
        check_field("status", int'(e.status), int'(status));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int settings[8];
    int push_bias[8];
    sched_result_t zero;
    settings = '{8, 1, 2, 5, 0, 15, 3, 8};
    push_bias = '{45, 70, 60, 40, 75, 35, 65, 50};
    zero = '0;
    sleeper_cnt = 0;
    workers_cfg = wsjs_pkg::MaxWorkers;
    for (int q = 0; q < wsjs_pkg::NumQueues; q++) begin
      q_head[q] = 0;
      q_fill[q] = 0;
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    req_type = '0;
    worker_id = '0;
    from_worker = 1'b0;
    job_id = '0;
    job_priority = '0;
    random_pick = '0;

    // Directed table, eight workers active after reset.
    add_row(wsjs_pkg::ReqGet, 0, 0, 0, 0, 0, 1, zero);
    add_row(ReqUnknown, 7, 1, 255, 3, 7, 1, zero);
    add_row(wsjs_pkg::ReqPush, 0, 0, 255, 3, 3, 1,
            '{1'b0, 8'd0, wsjs_pkg::SrcNone, 3'd3, 1'b0, wsjs_pkg::StOk});
    add_row(wsjs_pkg::ReqGet, 3, 0, 0, 0, 0, 1,
            '{1'b1, 8'd255, wsjs_pkg::SrcOwn, 3'd3, 1'b0, wsjs_pkg::StOk});
    add_row(wsjs_pkg::ReqSleep, 7, 0, 0, 0, 0, 1,
            '{1'b0, 8'd0, wsjs_pkg::SrcNone, 3'd7, 1'b0, wsjs_pkg::StOk});
    add_row(wsjs_pkg::ReqSleep, 7, 0, 0, 0, 0, 1,
            '{1'b0, 8'd0, wsjs_pkg::SrcNone, 3'd7, 1'b0, wsjs_pkg::StMisuse});
    add_row(wsjs_pkg::ReqPush, 0, 1, 0, 0, 0, 1,
            '{1'b0, 8'd0, wsjs_pkg::SrcNone, 3'd7, 1'b1, wsjs_pkg::StOk});
    add_row(wsjs_pkg::ReqGet, 0, 0, 0, 0, 6, 1,
            '{1'b1, 8'd0, wsjs_pkg::SrcSteal, 3'd7, 1'b0, wsjs_pkg::StOk});
    add_row(wsjs_pkg::ReqGet, 0, 0, 0, 0, 7, 1,
            '{1'b0, 8'd0, wsjs_pkg::SrcNone, 3'd0, 1'b0, wsjs_pkg::StRange});
    add_row(wsjs_pkg::ReqPush, 2, 1, 8'hAA, 0, 0, 0, zero);
    add_row(wsjs_pkg::ReqPush, 2, 1, 8'h55, 2, 7, 0, zero);
    add_row(wsjs_pkg::ReqPush, 2, 1, 8'h5A, 1, 7, 0, zero);
    add_row(wsjs_pkg::ReqGet, 2, 0, 0, 0, 0, 0, zero);
    add_row(wsjs_pkg::ReqGet, 1, 0, 0, 0, 1, 0, zero);
    add_row(wsjs_pkg::ReqGet, 1, 0, 0, 0, 1, 0, zero);
    for (int s = 0; s < wsjs_pkg::MaxWorkers; s++)
      add_row(wsjs_pkg::ReqSleep, s, 0, 0, 0, 0, 0, zero);
    add_row(wsjs_pkg::ReqPush, 4, 0, 8'h81, 2, 7, 0, zero);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < row_count; i++) send_request(directed_rows[i]);

    // Random phases across worker counts, clamped values included.
    for (int ph = 0; ph < 8; ph++) begin
      set_workers(settings[ph]);
      repeat (PhaseItems) send_request(random_request(push_bias[ph]));
    end

    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wsjs_pkg.sv
rtl/core/wsjs_ram.sv
rtl/core/wsjs_ctrl.sv
rtl/core/work_stealing_job_scheduler_unit.sv
rtl/core/wsjs_checker.sv
bench/tb.sv
